// ----- hdl/atf_pkg.sv -----
// Shared types and constants for the averaging tree filter.
// No dependencies; compiled before every other file of the block.
package atf_pkg;

    localparam int WINDOW_TAPS = 5;
    localparam int HIST_DEPTH  = WINDOW_TAPS - 1;
    localparam int KERNEL_BITS = 3;

    typedef enum logic [KERNEL_BITS-1:0] {
        KERNEL_11    = 3'd0,
        KERNEL_112   = 3'd1,
        KERNEL_1111  = 3'd2,
        KERNEL_1133  = 3'd3,
        KERNEL_13    = 3'd4,
        KERNEL_1339  = 3'd5,
        KERNEL_11446 = 3'd6,
        KERNEL_NONE  = 3'd7
    } kernel_t;

endpackage

// ----- hdl/atf_if.sv -----
// Valid/ready channel interfaces for the averaging tree filter.
// Standalone; the sample and result widths are set where they are instantiated.
interface atf_sample_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface atf_result_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink (input valid, input filtered, output ready);
endinterface

// ----- hdl/averaging_tree_filter_top.sv -----
// An accepted sample fills the window register; its result is held in result_reg.
// Throughput: one sample per cycle; the window register and the result register
// form a two-stage pipeline whose stages stall together when results back up.
// Reset clears the sample history to zero, sets the kernel to 0 and empties both stages.
// Depends on atf_pkg and the channel interfaces in atf_if.sv.
module averaging_tree_filter_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    atf_sample_if.sink                  sample_ch,
    atf_result_if.source                result_ch,
    input  logic                        cfg_wen,
    input  logic [atf_pkg::KERNEL_BITS-1:0] cfg_wdata
);
    import atf_pkg::*;

    localparam int W = SAMPLE_BITS;

    typedef logic [W-1:0] sample_t;

    function automatic sample_t half_up(sample_t a, sample_t b);
        logic [W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, 1'b1};
        return sum[W:1];
    endfunction

    function automatic sample_t half_dn(sample_t a, sample_t b);
        logic [W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[W:1];
    endfunction

    kernel_t kernel_reg;
    sample_t hist_reg [HIST_DEPTH];
    sample_t taps_reg [WINDOW_TAPS];
    logic    s1_valid_reg;
    logic    s1_valid_next;
    sample_t result_reg;
    sample_t result_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    accept;
    logic    advance;

    assign advance         = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign sample_ch.ready = !s1_valid_reg || advance;
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign s1_valid_next   = accept || (s1_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && !result_ch.ready);

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.filtered = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_11;
        end
        else if (cfg_wen)
        begin
            kernel_reg <= kernel_t'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < HIST_DEPTH - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[HIST_DEPTH-1] <= sample_ch.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                taps_reg[i] <= hist_reg[i];
            end
            taps_reg[HIST_DEPTH] <= sample_ch.sample;
        end
    end

    always_comb
    begin
        sample_t a, b, c, d, e, f, g, h, k, m;
        sample_t lo, hi, mid;
        a   = '0;
        b   = '0;
        c   = '0;
        d   = '0;
        e   = '0;
        f   = '0;
        g   = '0;
        h   = '0;
        k   = '0;
        m   = '0;
        lo  = '0;
        hi  = '0;
        mid = '0;
        result_next = '0;
        unique case (kernel_reg)
            KERNEL_11:
            begin
                m = half_up(taps_reg[0], taps_reg[1]);
                a = half_up(taps_reg[0], m);
                b = half_dn(taps_reg[1], m);
                result_next = half_dn(a, b);
            end
            KERNEL_112:
            begin
                a = half_up(taps_reg[1], taps_reg[2]);
                b = half_up(taps_reg[1], taps_reg[0]);
                result_next = half_dn(a, b);
            end
            KERNEL_1111:
            begin
                result_next = half_dn(half_up(taps_reg[0], taps_reg[1]),
                                      half_up(taps_reg[2], taps_reg[3]));
            end
            KERNEL_1133:
            begin
                lo  = half_dn(taps_reg[2], taps_reg[3]);
                hi  = half_up(taps_reg[2], taps_reg[3]);
                a   = half_up(taps_reg[0], taps_reg[1]);
                mid = half_up(lo, a);
                result_next = half_dn(hi, mid);
            end
            KERNEL_13:
            begin
                lo = half_dn(taps_reg[1], taps_reg[0]);
                hi = half_up(taps_reg[1], taps_reg[0]);
                a  = half_up(taps_reg[1], lo);
                b  = half_up(taps_reg[1], a);
                c  = half_dn(hi, a);
                result_next = half_dn(b, c);
            end
            KERNEL_1339:
            begin
                lo  = half_dn(taps_reg[3], taps_reg[0]);
                hi  = half_up(taps_reg[3], taps_reg[0]);
                mid = half_up(taps_reg[1], taps_reg[2]);
                a   = half_up(lo, mid);
                b   = half_up(hi, a);
                result_next = half_dn(taps_reg[1], b);
            end
            KERNEL_11446:
            begin
                a = half_dn(taps_reg[0], taps_reg[1]);
                b = half_dn(taps_reg[4], a);
                c = half_up(taps_reg[4], b);
                d = half_dn(taps_reg[2], taps_reg[3]);
                e = half_up(c, d);
                f = half_up(taps_reg[0], taps_reg[1]);
                g = half_up(taps_reg[4], f);
                h = half_up(taps_reg[4], g);
                k = half_up(taps_reg[2], taps_reg[3]);
                m = half_dn(h, k);
                result_next = half_dn(e, m);
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- hdl/atf_checker.sv -----
// Port-level checks for the averaging tree filter, bound to the top level.
// Depends on atf_pkg and on averaging_tree_filter_top.
module atf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [SAMPLE_BITS-1:0]          out_filtered,
    input logic                            cfg_wen,
    input logic [atf_pkg::KERNEL_BITS-1:0] cfg_wdata
);
    import atf_pkg::*;

    logic [KERNEL_BITS-1:0] kernel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_11;
        end
        else if (cfg_wen)
        begin
            kernel_reg <= cfg_wdata;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("Stalled result request changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("Sample request refused while the result stage is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("Accepted sample did not reach the output in two cycles.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kernel_reg == KERNEL_NONE) |-> out_filtered == '0)
    else $error("Unused kernel code gave a nonzero result.");

endmodule

bind averaging_tree_filter_top atf_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_atf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .out_filtered (result_ch.filtered),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for averaging_tree_filter_top: directed table, then random streams.
// Depends on atf_pkg, the channel interfaces in hdl/atf_if.sv and averaging_tree_filter_top; compiled after them.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import atf_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int RANDOM_ITEMS  = 617;
    localparam int LONG_STALL    = 300;
    localparam int MAX_REPORTS   = 10;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t window_t [WINDOW_TAPS];

    typedef struct {
        kernel_t kernel;
        sample_t sample;
        bit      fixed;
        sample_t filtered;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [KERNEL_BITS-1:0] cfg_wdata;

    atf_sample_if #(.W(SAMPLE_BITS)) sample_ch ();
    atf_result_if #(.W(SAMPLE_BITS)) result_ch ();

    averaging_tree_filter_top #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    sample_t expected_filtered [$];
    sample_t history [HIST_DEPTH];
    kernel_t active_kernel;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      stall_requests;
    int      mismatches;
    int      failures;

    directed_row_t directed_rows [23] = '{
        '{KERNEL_11,    16'h0000, 1'b1, 16'h0000},
        '{KERNEL_11,    16'hFFFF, 1'b1, 16'h0000},
        '{KERNEL_11,    16'hFFFF, 1'b0, 16'h0000},
        '{KERNEL_11,    16'hFFFF, 1'b0, 16'h0000},
        '{KERNEL_11,    16'hFFFF, 1'b0, 16'h0000},
        '{KERNEL_11,    16'hFFFF, 1'b1, 16'hFFFF},
        '{KERNEL_112,   16'hFFFF, 1'b1, 16'hFFFF},
        '{KERNEL_1111,  16'h0000, 1'b1, 16'hFFFF},
        '{KERNEL_1133,  16'h1234, 1'b0, 16'h0000},
        '{KERNEL_13,    16'h8000, 1'b0, 16'h0000},
        '{KERNEL_1339,  16'h0001, 1'b0, 16'h0000},
        '{KERNEL_11446, 16'hFFFF, 1'b0, 16'h0000},
        '{KERNEL_11446, 16'h0000, 1'b0, 16'h0000},
        '{KERNEL_NONE,  16'hABCD, 1'b1, 16'h0000},
        '{KERNEL_NONE,  16'h5555, 1'b1, 16'h0000},
        '{KERNEL_11446, 16'hAAAA, 1'b0, 16'h0000},
        '{KERNEL_1339,  16'h7FFF, 1'b0, 16'h0000},
        '{KERNEL_13,    16'h0000, 1'b0, 16'h0000},
        '{KERNEL_1133,  16'hFFFF, 1'b0, 16'h0000},
        '{KERNEL_1111,  16'h8001, 1'b0, 16'h0000},
        '{KERNEL_112,   16'h0000, 1'b0, 16'h0000},
        '{KERNEL_11,    16'hFFFE, 1'b0, 16'h0000},
        '{KERNEL_11446, 16'h0000, 1'b0, 16'h0000}
    };

    function automatic sample_t avg_up(sample_t a, sample_t b);
        logic [SAMPLE_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{SAMPLE_BITS{1'b0}}, 1'b1};
        return sum[SAMPLE_BITS:1];
    endfunction

    function automatic sample_t avg_down(sample_t a, sample_t b);
        logic [SAMPLE_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SAMPLE_BITS:1];
    endfunction

    function automatic sample_t tree_output(kernel_t kernel, window_t t);
        sample_t a, b, c, d, e, f, g, h, k, m;
        a = '0; b = '0; c = '0; d = '0; e = '0;
        f = '0; g = '0; h = '0; k = '0; m = '0;
        case (kernel)
            KERNEL_11:
            begin
                m = avg_up(t[0], t[1]);
                return avg_down(avg_up(t[0], m), avg_down(t[1], m));
            end
            KERNEL_112:
                return avg_down(avg_up(t[1], t[2]), avg_up(t[1], t[0]));
            KERNEL_1111:
                return avg_down(avg_up(t[0], t[1]), avg_up(t[2], t[3]));
            KERNEL_1133:
            begin
                a = avg_down(t[2], t[3]);
                b = avg_up(t[2], t[3]);
                c = avg_up(t[0], t[1]);
                d = avg_up(a, c);
                return avg_down(b, d);
            end
            KERNEL_13:
            begin
                a = avg_down(t[1], t[0]);
                b = avg_up(t[1], t[0]);
                c = avg_up(t[1], a);
                d = avg_up(t[1], c);
                e = avg_down(b, c);
                return avg_down(d, e);
            end
            KERNEL_1339:
            begin
                a = avg_down(t[3], t[0]);
                b = avg_up(t[3], t[0]);
                c = avg_up(t[1], t[2]);
                d = avg_up(a, c);
                e = avg_up(b, d);
                return avg_down(t[1], e);
            end
            KERNEL_11446:
            begin
                a = avg_down(t[0], t[1]);
                b = avg_down(t[4], a);
                c = avg_up(t[4], b);
                d = avg_down(t[2], t[3]);
                e = avg_up(c, d);
                f = avg_up(t[0], t[1]);
                g = avg_up(t[4], f);
                h = avg_up(t[4], g);
                k = avg_up(t[2], t[3]);
                m = avg_down(h, k);
                return avg_down(e, m);
            end
            default:
                return '0;
        endcase
    endfunction

    function automatic sample_t advance_window(sample_t value);
        window_t taps;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            taps[i] = history[i];
        end
        taps[HIST_DEPTH] = value;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            history[i] = taps[i + 1];
        end
        return tree_output(active_kernel, taps);
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return sample_t'($urandom_range(0, 15));
            3:       return sample_t'(16'hFFFF - $urandom_range(0, 15));
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic kernel_t random_kernel();
        if ($urandom_range(0, 9) == 0)
            return KERNEL_NONE;
        return kernel_t'($urandom_range(0, 6));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is accepted.
    task automatic send_sample(sample_t value, bit fixed, sample_t fixed_filtered);
        sample_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = advance_window(value);
        expected_filtered.push_back(fixed ? fixed_filtered : predicted);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_filtered.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_kernel(kernel_t kernel);
        wait_for_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= kernel;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        active_kernel = kernel;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    // The receiver holds ready low for a long stretch whenever the stimulus asks for it.
    initial
    begin
        int served;
        int hold;
        served = 0;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (served != stall_requests)
            begin
                served = stall_requests;
                hold = LONG_STALL;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_filtered.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: filtered=%h", result_ch.filtered);
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (result_ch.filtered !== want)
                begin
                    failures++;
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: filtered expected %h actual %h",
                                 want, result_ch.filtered);
                end
            end
        end
    end

    initial
    begin
        int left;
        int count;
        int group;
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        cfg_wen          = 1'b0;
        cfg_wdata        = '0;
        stall_requests   = 0;
        mismatches       = 0;
        failures         = 0;
        active_kernel    = KERNEL_11;
        send_idle_pct    = 8;
        recv_idle_pct    = 78;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            history[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kernel != active_kernel)
                write_kernel(directed_rows[i].kernel);
            send_sample(directed_rows[i].sample, directed_rows[i].fixed,
                        directed_rows[i].filtered);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 8 : 0;
            left = RANDOM_ITEMS;
            group = 0;
            while (left > 0)
            begin
                count = $urandom_range(20, 80);
                if (count > left)
                    count = left;
                if (group == 0)
                    write_kernel((phase == 1) ? KERNEL_NONE : KERNEL_11446);
                else
                    write_kernel(random_kernel());
                // The block backs up and must stall new requests during this stall.
                if (group == 1)
                    stall_requests++;
                for (int n = 0; n < count; n++)
                begin
                    send_sample(random_sample(), 1'b0, '0);
                end
                left -= count;
                group++;
            end
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        failures += expected_filtered.size();
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
